/* design/ufcec_pkg.sv */
// shared constants, state encoding and memory control type for the cycle edge counter
package ufcec_pkg;

    localparam int DEF_NODE_COUNT  = 1024;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int NODE_IN_W   = 10;
    localparam int COUNT_OUT_W = 16;
    localparam int RANK_W      = 4;
    localparam int EPOCH_W     = 8;

    localparam logic [RANK_W-1:0]  RANK_MAX    = 4'd15;
    localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = 8'd0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_FIND_ISSUE,
        S_FIND,
        S_COMP_ISSUE,
        S_COMP,
        S_UNION,
        S_RANK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } mem_ctrl_t;

endpackage

/* design/ufcec_forest.sv */
// forest memory: parent, rank and epoch tag per node, registered read, tag check on output
module ufcec_forest #(
    parameter int NODE_COUNT = ufcec_pkg::DEF_NODE_COUNT,
    parameter int IDX_W      = $clog2(ufcec_pkg::DEF_NODE_COUNT)
) (
    input  logic                          clk,
    input  ufcec_pkg::mem_ctrl_t          ctrl,
    input  logic [ufcec_pkg::EPOCH_W-1:0] epoch,
    input  logic [IDX_W-1:0]              rd_addr,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [IDX_W-1:0]              wr_parent,
    input  logic [ufcec_pkg::RANK_W-1:0]  wr_rank,
    output logic [IDX_W-1:0]              rd_parent,
    output logic [ufcec_pkg::RANK_W-1:0]  rd_rank
);

    localparam int ENTRY_W = ufcec_pkg::EPOCH_W + ufcec_pkg::RANK_W + IDX_W;

    logic [ENTRY_W-1:0] mem [NODE_COUNT];
    logic [ENTRY_W-1:0] wr_word;
    logic [ENTRY_W-1:0] rd_word_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic               hit;

    // a cleared entry carries a tag that no live epoch uses
    always_comb
    begin
        if (ctrl.clear)
        begin
            wr_word = {ufcec_pkg::EPOCH_CLEAR, {(ENTRY_W - ufcec_pkg::EPOCH_W){1'b0}}};
        end
        else
        begin
            wr_word = {epoch, wr_rank, wr_parent};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (ctrl.rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // stale tag: node is its own root with rank zero
    assign hit       = (rd_word_reg[ENTRY_W-1 -: ufcec_pkg::EPOCH_W] == epoch);
    assign rd_parent = hit ? rd_word_reg[IDX_W-1:0] : rd_addr_reg;
    assign rd_rank   = hit ? rd_word_reg[IDX_W +: ufcec_pkg::RANK_W] : '0;

endmodule

/* design/union_find_cycle_edge_counter.sv */
// top level: disjoint-set cycle edge counter with a sequencer around the forest memory
//
// usage
//   edge channel: edge_valid / edge_stall with node_a, node_b and last_edge. one item is one
//   undirected edge. result channel: result_valid / result_stall with refused, refusal_count
//   and case_done, exactly one result item per edge item, in order.
//   each edge walks from each endpoint to its root and compresses that path before its
//   result is given, with one more write when a root rank rises; the walk reads the single
//   read port of the forest memory once a cycle, and compression writes share the same
//   cycles. the next edge is taken once the sequencer is back in idle after the result.
//   with a node count below 1024 that is not a power of two, the indices are first reduced
//   by a reciprocal multiply and subtract. one edge is worked on at a time.
//   after reset, and after every 255th finished case, a clearing pass over all NODE_COUNT
//   entries sweeps the epoch tags; edge_stall stays high meanwhile. other cases end by
//   stepping the epoch, so the forest is empty again at once.
//   a finished result sits in the output register; when the receiver stalls it holds there,
//   the next edge is still taken and worked on, and only its own result waits for the slot.
module union_find_cycle_edge_counter #(
    parameter int NODE_COUNT  = ufcec_pkg::DEF_NODE_COUNT,
    parameter int COUNT_WIDTH = ufcec_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              edge_valid,
    output logic                              edge_stall,
    input  logic [ufcec_pkg::NODE_IN_W-1:0]   node_a,
    input  logic [ufcec_pkg::NODE_IN_W-1:0]   node_b,
    input  logic                              last_edge,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              refused,
    output logic [ufcec_pkg::COUNT_OUT_W-1:0] refusal_count,
    output logic                              case_done
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int IN_W   = ufcec_pkg::NODE_IN_W;
    localparam int EXT_W  = (IDX_W > IN_W) ? IDX_W : IN_W;
    localparam int RED_W  = 2 * IN_W;
    localparam int STEP_W = $clog2(IN_W);
    localparam bit REDUCE = (NODE_COUNT < (2 ** IN_W)) &&
                            ((NODE_COUNT & (NODE_COUNT - 1)) != 0);

    // reciprocal rounded up, exact quotient for every index of IN_W bits
    localparam int RCP_SH = IN_W + IDX_W;
    localparam int RCP_W  = IN_W + 2;
    localparam int PROD_W = IN_W + RCP_W;
    localparam int RCP    = ((2 ** RCP_SH) + NODE_COUNT - 1) / NODE_COUNT;

    localparam logic [STEP_W-1:0]      STEP_TOP  = STEP_W'(1);
    localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NODE_COUNT - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    ufcec_pkg::state_t state_reg, state_next;

    // item registers
    logic [IN_W-1:0]   rem_a_reg, rem_a_next;
    logic [IN_W-1:0]   rem_b_reg, rem_b_next;
    logic [IN_W-1:0]   quo_a_reg, quo_a_next;
    logic [IN_W-1:0]   quo_b_reg, quo_b_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_reg, last_next;
    logic              side_reg, side_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  root_a_reg, root_a_next;
    logic [IDX_W-1:0]  root_b_reg, root_b_next;
    logic [ufcec_pkg::RANK_W-1:0] rank_a_reg, rank_a_next;
    logic [ufcec_pkg::RANK_W-1:0] rank_b_reg, rank_b_next;
    logic              refused_reg, refused_next;

    // case and housekeeping state
    logic [COUNT_WIDTH-1:0]        cnt_reg, cnt_next;
    logic [ufcec_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]              clr_addr_reg, clr_addr_next;

    // result slot
    logic                              result_valid_reg, result_valid_next;
    logic                              refused_out_reg, refused_out_next;
    logic [ufcec_pkg::COUNT_OUT_W-1:0] count_out_reg, count_out_next;
    logic                              case_done_reg, case_done_next;

    // memory port
    ufcec_pkg::mem_ctrl_t         mem_ctrl;
    logic [IDX_W-1:0]             rd_addr;
    logic [IDX_W-1:0]             wr_addr;
    logic [IDX_W-1:0]             wr_parent;
    logic [ufcec_pkg::RANK_W-1:0] wr_rank;
    logic [IDX_W-1:0]             rd_parent;
    logic [ufcec_pkg::RANK_W-1:0] rd_rank;

    // helpers
    logic [EXT_W-1:0]  ext_a, ext_b;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  root_cur;
    logic [PROD_W-1:0] prod_a, prod_b;
    logic [RED_W-1:0]  back_a, back_b;
    logic [31:0]       cnt_wide;
    logic              same_root;
    logic              accept;
    logic              done_go;

    ufcec_forest #(
        .NODE_COUNT (NODE_COUNT),
        .IDX_W      (IDX_W)
    ) u_forest (
        .clk       (clk),
        .ctrl      (mem_ctrl),
        .epoch     (epoch_reg),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_parent (wr_parent),
        .wr_rank   (wr_rank),
        .rd_parent (rd_parent),
        .rd_rank   (rd_rank)
    );

    // after reduction the index is below NODE_COUNT, so the low bits are the node
    assign ext_a     = EXT_W'(rem_a_reg);
    assign ext_b     = EXT_W'(rem_b_reg);
    assign start_idx = side_reg ? ext_b[IDX_W-1:0] : ext_a[IDX_W-1:0];
    assign root_cur  = side_reg ? root_b_reg : root_a_reg;
    assign same_root = (root_a_reg == root_b_reg);

    // quotient by reciprocal multiply, then multiply back and subtract for the remainder
    assign prod_a = PROD_W'(rem_a_reg) * PROD_W'(RCP);
    assign prod_b = PROD_W'(rem_b_reg) * PROD_W'(RCP);
    assign back_a = RED_W'(quo_a_reg) * RED_W'(NODE_COUNT);
    assign back_b = RED_W'(quo_b_reg) * RED_W'(NODE_COUNT);

    assign edge_stall = (state_reg != ufcec_pkg::S_IDLE);
    assign accept     = edge_valid && !edge_stall;
    assign done_go    = (state_reg == ufcec_pkg::S_DONE) &&
                        (!result_valid_reg || !result_stall);
    assign cnt_wide   = 32'(cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ufcec_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ufcec_pkg::S_IDLE;
                end
            end
            ufcec_pkg::S_IDLE:
            begin
                if (edge_valid)
                begin
                    state_next = REDUCE ? ufcec_pkg::S_REDUCE : ufcec_pkg::S_FIND_ISSUE;
                end
            end
            ufcec_pkg::S_REDUCE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ufcec_pkg::S_FIND_ISSUE;
                end
            end
            ufcec_pkg::S_FIND_ISSUE:
            begin
                state_next = ufcec_pkg::S_FIND;
            end
            ufcec_pkg::S_FIND:
            begin
                if (rd_parent == cur_reg)
                begin
                    state_next = ufcec_pkg::S_COMP_ISSUE;
                end
            end
            ufcec_pkg::S_COMP_ISSUE:
            begin
                if (start_idx == root_cur)
                begin
                    state_next = side_reg ? ufcec_pkg::S_UNION : ufcec_pkg::S_FIND_ISSUE;
                end
                else
                begin
                    state_next = ufcec_pkg::S_COMP;
                end
            end
            ufcec_pkg::S_COMP:
            begin
                if (rd_parent == root_cur)
                begin
                    state_next = side_reg ? ufcec_pkg::S_UNION : ufcec_pkg::S_FIND_ISSUE;
                end
            end
            ufcec_pkg::S_UNION:
            begin
                if (!same_root && (rank_a_reg == rank_b_reg))
                begin
                    state_next = ufcec_pkg::S_RANK;
                end
                else
                begin
                    state_next = ufcec_pkg::S_DONE;
                end
            end
            ufcec_pkg::S_RANK:
            begin
                state_next = ufcec_pkg::S_DONE;
            end
            ufcec_pkg::S_DONE:
            begin
                if (done_go)
                begin
                    if (last_reg && (epoch_reg == ufcec_pkg::EPOCH_LAST))
                    begin
                        state_next = ufcec_pkg::S_CLEAR;
                    end
                    else
                    begin
                        state_next = ufcec_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ufcec_pkg::S_CLEAR;
            end
        endcase
    end

    // memory port drive
    always_comb
    begin
        mem_ctrl  = '0;
        rd_addr   = cur_reg;
        wr_addr   = cur_reg;
        wr_parent = root_cur;
        wr_rank   = rd_rank;
        unique case (state_reg)
            ufcec_pkg::S_CLEAR:
            begin
                mem_ctrl.wr_en = 1'b1;
                mem_ctrl.clear = 1'b1;
                wr_addr        = clr_addr_reg;
            end
            ufcec_pkg::S_FIND_ISSUE:
            begin
                mem_ctrl.rd_en = 1'b1;
                rd_addr        = start_idx;
            end
            ufcec_pkg::S_FIND:
            begin
                mem_ctrl.rd_en = (rd_parent != cur_reg);
                rd_addr        = rd_parent;
            end
            ufcec_pkg::S_COMP_ISSUE:
            begin
                mem_ctrl.rd_en = (start_idx != root_cur);
                rd_addr        = start_idx;
            end
            ufcec_pkg::S_COMP:
            begin
                // point the node just read at the root, fetch the next one on the path
                mem_ctrl.wr_en = 1'b1;
                wr_addr        = cur_reg;
                wr_parent      = root_cur;
                wr_rank        = rd_rank;
                mem_ctrl.rd_en = (rd_parent != root_cur);
                rd_addr        = rd_parent;
            end
            ufcec_pkg::S_UNION:
            begin
                mem_ctrl.wr_en = !same_root;
                if (rank_a_reg > rank_b_reg)
                begin
                    wr_addr   = root_b_reg;
                    wr_parent = root_a_reg;
                    wr_rank   = rank_b_reg;
                end
                else
                begin
                    wr_addr   = root_a_reg;
                    wr_parent = root_b_reg;
                    wr_rank   = rank_a_reg;
                end
            end
            ufcec_pkg::S_RANK:
            begin
                mem_ctrl.wr_en = 1'b1;
                wr_addr        = root_b_reg;
                wr_parent      = root_b_reg;
                wr_rank        = (rank_b_reg == ufcec_pkg::RANK_MAX) ?
                                 ufcec_pkg::RANK_MAX : rank_b_reg + 1'b1;
            end
            ufcec_pkg::S_IDLE,
            ufcec_pkg::S_REDUCE,
            ufcec_pkg::S_DONE:
            begin
                mem_ctrl = '0;
            end
            default:
            begin
                mem_ctrl = '0;
            end
        endcase
    end

    // datapath register updates
    always_comb
    begin
        rem_a_next        = rem_a_reg;
        rem_b_next        = rem_b_reg;
        quo_a_next        = quo_a_reg;
        quo_b_next        = quo_b_reg;
        step_next         = step_reg;
        last_next         = last_reg;
        side_next         = side_reg;
        cur_next          = cur_reg;
        root_a_next       = root_a_reg;
        root_b_next       = root_b_reg;
        rank_a_next       = rank_a_reg;
        rank_b_next       = rank_b_reg;
        refused_next      = refused_reg;
        cnt_next          = cnt_reg;
        epoch_next        = epoch_reg;
        clr_addr_next     = clr_addr_reg;
        result_valid_next = result_valid_reg && result_stall;
        refused_out_next  = refused_out_reg;
        count_out_next    = count_out_reg;
        case_done_next    = case_done_reg;

        case (state_reg)
            ufcec_pkg::S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX)
                begin
                    clr_addr_next = '0;
                    epoch_next    = ufcec_pkg::EPOCH_FIRST;
                end
            end
            ufcec_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    rem_a_next = node_a;
                    rem_b_next = node_b;
                    last_next  = last_edge;
                    step_next  = STEP_TOP;
                    side_next  = 1'b0;
                end
            end
            ufcec_pkg::S_REDUCE:
            begin
                if (step_reg == STEP_TOP)
                begin
                    quo_a_next = IN_W'(prod_a >> RCP_SH);
                    quo_b_next = IN_W'(prod_b >> RCP_SH);
                end
                else
                begin
                    rem_a_next = rem_a_reg - back_a[IN_W-1:0];
                    rem_b_next = rem_b_reg - back_b[IN_W-1:0];
                end
                step_next = step_reg - 1'b1;
            end
            ufcec_pkg::S_FIND_ISSUE:
            begin
                cur_next = start_idx;
            end
            ufcec_pkg::S_FIND:
            begin
                if (rd_parent == cur_reg)
                begin
                    if (side_reg)
                    begin
                        root_b_next = cur_reg;
                        rank_b_next = rd_rank;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        rank_a_next = rd_rank;
                    end
                end
                else
                begin
                    cur_next = rd_parent;
                end
            end
            ufcec_pkg::S_COMP_ISSUE:
            begin
                cur_next = start_idx;
                if (start_idx == root_cur)
                begin
                    side_next = 1'b1;
                end
            end
            ufcec_pkg::S_COMP:
            begin
                cur_next = rd_parent;
                if (rd_parent == root_cur)
                begin
                    side_next = 1'b1;
                end
            end
            ufcec_pkg::S_UNION:
            begin
                refused_next = same_root;
                if (same_root && (cnt_reg != COUNT_MAX))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ufcec_pkg::S_DONE:
            begin
                if (done_go)
                begin
                    result_valid_next = 1'b1;
                    refused_out_next  = refused_reg;
                    count_out_next    = cnt_wide[ufcec_pkg::COUNT_OUT_W-1:0];
                    case_done_next    = last_reg;
                    if (last_reg)
                    begin
                        cnt_next = '0;
                        if (epoch_reg != ufcec_pkg::EPOCH_LAST)
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ufcec_pkg::S_CLEAR;
            cnt_reg          <= '0;
            epoch_reg        <= ufcec_pkg::EPOCH_FIRST;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            side_reg         <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            epoch_reg        <= epoch_next;
            clr_addr_reg     <= clr_addr_next;
            result_valid_reg <= result_valid_next;
            side_reg         <= side_next;
            step_reg         <= step_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_a_reg       <= rem_a_next;
        rem_b_reg       <= rem_b_next;
        quo_a_reg       <= quo_a_next;
        quo_b_reg       <= quo_b_next;
        last_reg        <= last_next;
        cur_reg         <= cur_next;
        root_a_reg      <= root_a_next;
        root_b_reg      <= root_b_next;
        rank_a_reg      <= rank_a_next;
        rank_b_reg      <= rank_b_next;
        refused_reg     <= refused_next;
        refused_out_reg <= refused_out_next;
        count_out_reg   <= count_out_next;
        case_done_reg   <= case_done_next;
    end

    assign result_valid  = result_valid_reg;
    assign refused       = refused_out_reg;
    assign refusal_count = count_out_reg;
    assign case_done     = case_done_reg;

    // an accepted edge always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ufcec_pkg::S_IDLE))
        else $error("edge accepted but sequencer stayed idle");

    // compression never rewrites the root itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufcec_pkg::S_COMP) |-> (cur_reg != root_cur))
        else $error("compression walked onto the root");

    // the end of a case leaves the refusal count at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_go && last_reg) |=> (cnt_reg == '0))
        else $error("refusal count not cleared after last edge");

endmodule
